FILE: rtl/cau_pkg.sv
package cau_pkg;

	localparam int DATA_W    = 16;
	localparam int FRAC_BITS = 8;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int RAD_W     = PROD_W;
	localparam int REM_W     = DATA_W + 2;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (DATA_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_SUB = 3'd1,
		MODE_MUL = 3'd2,
		MODE_EQ  = 3'd3,
		MODE_MAG = 3'd4
	} mode_t;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [DATA_W-1:0] a_real;
		logic signed [DATA_W-1:0] a_imag;
		logic signed [DATA_W-1:0] b_real;
		logic signed [DATA_W-1:0] b_imag;
	} op_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] res_real;
		logic signed [DATA_W-1:0] res_imag;
		logic [DATA_W-1:0]        magnitude;
		logic                     is_equal;
		logic                     saturated;
	} res_item_t;

	// products and early results after the first stage
	typedef struct packed {
		logic                     is_mul;
		logic                     is_mag;
		logic signed [PROD_W-1:0] p0;
		logic signed [PROD_W-1:0] p1;
		logic signed [PROD_W-1:0] p2;
		logic signed [PROD_W-1:0] p3;
		res_item_t                res;
	} front_t;

	// word handed along the root chain
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [DATA_W-1:0] root;
		res_item_t         res;
	} sq_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     sat;
	} sat_t;

	function automatic sat_t clamp_fn(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > SAT_HI) begin
			r.val = SAT_HI[DATA_W-1:0];
			r.sat = 1'b1;
		end else if (v < SAT_LO) begin
			r.val = SAT_LO[DATA_W-1:0];
			r.sat = 1'b1;
		end else begin
			r.val = v[DATA_W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/cau_front.sv
module cau_front import cau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  op_item_t op,
	output logic     valid_s1,
	output front_t   data_s1
);

	logic signed [DATA_W-1:0] m0_b, m1_b;
	sat_t   cr, ci;
	front_t nxt;

	// magnitude reuses the first two multipliers as squarers
	assign m0_b = (op.mode == MODE_MAG) ? op.a_real : op.b_real;
	assign m1_b = (op.mode == MODE_MAG) ? op.a_imag : op.b_imag;

	always_comb begin
		cr  = '0;
		ci  = '0;
		nxt = '0;
		nxt.p0 = PROD_W'(op.a_real) * PROD_W'(m0_b);
		nxt.p1 = PROD_W'(op.a_imag) * PROD_W'(m1_b);
		nxt.p2 = PROD_W'(op.a_real) * PROD_W'(op.b_imag);
		nxt.p3 = PROD_W'(op.a_imag) * PROD_W'(op.b_real);
		unique case (op.mode)
			MODE_ADD: begin
				cr = clamp_fn(SUM_W'(op.a_real) + SUM_W'(op.b_real));
				ci = clamp_fn(SUM_W'(op.a_imag) + SUM_W'(op.b_imag));
				nxt.res.res_real  = cr.val;
				nxt.res.res_imag  = ci.val;
				nxt.res.saturated = cr.sat | ci.sat;
			end
			MODE_SUB: begin
				cr = clamp_fn(SUM_W'(op.a_real) - SUM_W'(op.b_real));
				ci = clamp_fn(SUM_W'(op.a_imag) - SUM_W'(op.b_imag));
				nxt.res.res_real  = cr.val;
				nxt.res.res_imag  = ci.val;
				nxt.res.saturated = cr.sat | ci.sat;
			end
			MODE_MUL: nxt.is_mul = 1'b1;
			MODE_EQ:  nxt.res.is_equal = (op.a_real == op.b_real) && (op.a_imag == op.b_imag);
			MODE_MAG: nxt.is_mag = 1'b1;
			default:  nxt.is_mul = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/cau_combine.sv
module cau_combine import cau_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  front_t data_s1,
	output logic   valid_s2,
	output sq_t    data_s2
);

	logic signed [SUM_W-1:0] re_full, im_full;
	sat_t cr, ci;
	sq_t  nxt;

	// floor of the exact sum, then clamp
	assign re_full = (SUM_W'(data_s1.p0) - SUM_W'(data_s1.p1)) >>> FRAC_BITS;
	assign im_full = (SUM_W'(data_s1.p2) + SUM_W'(data_s1.p3)) >>> FRAC_BITS;
	assign cr = clamp_fn(re_full);
	assign ci = clamp_fn(im_full);

	always_comb begin
		nxt      = '0;
		nxt.res  = data_s1.res;
		if (data_s1.is_mul) begin
			nxt.res.res_real  = cr.val;
			nxt.res.res_imag  = ci.val;
			nxt.res.saturated = cr.sat | ci.sat;
		end
		if (data_s1.is_mag) begin
			nxt.rad = RAD_W'($unsigned(data_s1.p0)) + RAD_W'($unsigned(data_s1.p1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule

FILE: rtl/cau_sqrt_cell.sv
module cau_sqrt_cell import cau_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  sq_t  sq_in,
	output logic valid_q,
	output sq_t  sq_q
);

	logic [REM_W+1:0] trial, divisor, diff;
	logic             ge;
	sq_t              nxt;

	// one root bit per cell: bring down two radicand bits, try 4q+1
	assign trial   = {sq_in.rem, sq_in.rad[RAD_W-1 -: 2]};
	assign divisor = {2'b00, sq_in.root, 2'b01};
	assign ge      = (trial >= divisor);
	assign diff    = trial - divisor;

	always_comb begin
		nxt      = sq_in;
		nxt.rad  = {sq_in.rad[RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		nxt.root = {sq_in.root[DATA_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q <= nxt;
		end
	end

endmodule

FILE: rtl/complex_arith_unit_top.sv
// complex arithmetic unit, Q7.8 fixed point: each transfer on the op channel carries a mode
// (add, subtract, multiply, equality test, magnitude of a) and two complex operands, and
// produces exactly one transfer on the res channel, in order. the unit takes one item every
// cycle while the res side keeps up, and holds up to eighteen items in flight: one stage for
// the four 16x16 multipliers and the add/subtract/compare logic, one stage for the product
// sums, floor and clamp, and a chain of sixteen square-root cells that each settle one bit
// of the magnitude. every stage has its own valid bit and loads whenever it is empty or its
// successor moves on, so bubbles close up under back pressure and op_ready only drops once
// the whole chain is full and res is not taken
module complex_arith_unit_top import cau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_ready,
	input  op_item_t  op,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	localparam int NSTG = DATA_W + 2;

	// per-stage valid bits and load enables
	logic [NSTG-1:0] vld;
	logic [NSTG:0]   rdy;
	front_t          front_s1;
	sq_t             sq_d [DATA_W+1];

	// a stage may load when it is empty or its contents leave this cycle
	// evaluated from the output end back towards the input
	always_comb begin
		rdy[NSTG] = res_ready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !vld[i] || rdy[i+1];
		end
	end

	assign op_ready = rdy[0];

	// multipliers, add/subtract and equality
	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy[0]),
		.in_valid (op_valid),
		.op       (op),
		.valid_s1 (vld[0]),
		.data_s1  (front_s1)
	);

	// product sums with floor and saturation, radicand for the magnitude
	cau_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (rdy[1]),
		.in_valid (vld[0]),
		.data_s1  (front_s1),
		.valid_s2 (vld[1]),
		.data_s2  (sq_d[0])
	);

	// square-root chain, most significant root bit first
	for (genvar k = 0; k < DATA_W; k++) begin : g_cell
		cau_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (rdy[k+2]),
			.in_valid (vld[k+1]),
			.sq_in    (sq_d[k]),
			.valid_q  (vld[k+2]),
			.sq_q     (sq_d[k+1])
		);
	end

	// last cell doubles as the output register
	assign res_valid = vld[NSTG-1];
	always_comb begin
		res           = sq_d[DATA_W].res;
		res.magnitude = sq_d[DATA_W].root;
	end

endmodule

FILE: rtl/cau_checker.sv
module cau_checker import cau_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      op_ready,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// an equality result carries nothing else
	a_eq_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.is_equal |->
			res.res_real == '0 && res.res_imag == '0 && res.magnitude == '0 && !res.saturated)
		else $error("equality result has stray fields");

	// a magnitude result carries no complex part and never clamps at this width
	a_mag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.magnitude != '0 |->
			res.res_real == '0 && res.res_imag == '0 && !res.saturated)
		else $error("magnitude result has stray fields");

	// an idle output side never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> op_ready)
		else $error("input stalled with empty output");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

// self-checking bench for the complex arithmetic unit: a directed opening, then a long run of
// random operand pairs over every mode, with random idling on both channels
module tb_top;
	import cau_pkg::*;

	// codes that the package enum leaves out; the unit must answer them with an all-zero result
	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	localparam int RANDOM_OPS   = 450;
	// pipeline is eighteen deep, so this covers any straggler after the last result
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7fff;
	localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;
	localparam logic signed [DATA_W-1:0] Q_ONE = 16'sh0100;

	// expected results held in transfer order, built by a bit-true predictor of the unit
	class cplx_scoreboard;
		res_item_t pending_results[$];
		int        errors = 0;

		function automatic logic signed [DATA_W-1:0] clamp_part(input longint v,
				inout bit clamped);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (DATA_W - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				clamped = 1'b1;
				return hi[DATA_W-1:0];
			end
			if (v < lo) begin
				clamped = 1'b1;
				return lo[DATA_W-1:0];
			end
			return v[DATA_W-1:0];
		endfunction

		function automatic longint floor_sqrt(input longint n);
			longint root;
			longint bitv;
			root = 0;
			bitv = longint'(1) <<< 62;
			while (bitv > n)
				bitv = bitv >>> 2;
			while (bitv != 0) begin
				if (n >= root + bitv) begin
					n    = n - (root + bitv);
					root = (root >>> 1) + bitv;
				end else begin
					root = root >>> 1;
				end
				bitv = bitv >>> 2;
			end
			return root;
		endfunction

		function automatic res_item_t compute_result(input op_item_t it);
			res_item_t r;
			longint    ar;
			longint    ai;
			longint    br;
			longint    bi;
			longint    mag;
			bit        clamped;
			ar      = longint'(it.a_real);
			ai      = longint'(it.a_imag);
			br      = longint'(it.b_real);
			bi      = longint'(it.b_imag);
			r       = '0;
			clamped = 1'b0;
			case (it.mode)
				MODE_ADD: begin
					r.res_real = clamp_part(ar + br, clamped);
					r.res_imag = clamp_part(ai + bi, clamped);
				end
				MODE_SUB: begin
					r.res_real = clamp_part(ar - br, clamped);
					r.res_imag = clamp_part(ai - bi, clamped);
				end
				MODE_MUL: begin
					// exact sum of the cross products, floored by the fraction bits
					r.res_real = clamp_part((ar * br - ai * bi) >>> FRAC_BITS, clamped);
					r.res_imag = clamp_part((ar * bi + ai * br) >>> FRAC_BITS, clamped);
				end
				MODE_EQ: begin
					r.is_equal = (ar == br) && (ai == bi);
				end
				MODE_MAG: begin
					mag = floor_sqrt(ar * ar + ai * ai);
					if (mag > (longint'(1) <<< DATA_W) - 1) begin
						mag     = (longint'(1) <<< DATA_W) - 1;
						clamped = 1'b1;
					end
					r.magnitude = mag[DATA_W-1:0];
				end
				default: begin
				end
			endcase
			r.saturated = clamped;
			return r;
		endfunction

		function void note_op(input op_item_t it);
			pending_results.push_back(compute_result(it));
		endfunction

		function void check_res(input res_item_t got);
			res_item_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing outstanding, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.res_real !== want.res_real) begin
				$display("%0t: res_real expected %h actual %h", $time, want.res_real,
					got.res_real);
				errors++;
			end
			if (got.res_imag !== want.res_imag) begin
				$display("%0t: res_imag expected %h actual %h", $time, want.res_imag,
					got.res_imag);
				errors++;
			end
			if (got.magnitude !== want.magnitude) begin
				$display("%0t: magnitude expected %h actual %h", $time, want.magnitude,
					got.magnitude);
				errors++;
			end
			if (got.is_equal !== want.is_equal) begin
				$display("%0t: is_equal expected %b actual %b", $time, want.is_equal,
					got.is_equal);
				errors++;
			end
			if (got.saturated !== want.saturated) begin
				$display("%0t: saturated expected %b actual %b", $time, want.saturated,
					got.saturated);
				errors++;
			end
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      op_valid;
	logic      op_ready;
	op_item_t  op;
	logic      res_valid;
	logic      res_ready;
	res_item_t res;

	cplx_scoreboard sb = new();
	// when clear, both sides run flat out with no idle cycles
	bit             idle_on;
	int             cycle_count = 0;

	complex_arith_unit_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// watchdog: a hung handshake or a lost result ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic op_item_t make_op(input logic [2:0] m,
			input logic signed [DATA_W-1:0] ar, input logic signed [DATA_W-1:0] ai,
			input logic signed [DATA_W-1:0] br, input logic signed [DATA_W-1:0] bi);
		op_item_t it;
		it.mode   = m;
		it.a_real = ar;
		it.a_imag = ai;
		it.b_real = br;
		it.b_imag = bi;
		return it;
	endfunction

	// operand part: full-range noise, small values near zero, or one of the corner codes
	function automatic logic signed [DATA_W-1:0] rand_part();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = DATA_W'($urandom_range(0, 1023)) - 16'sd512;
			1: begin
				case ($urandom_range(0, 4))
					0: v = Q_MAX;
					1: v = Q_MIN;
					2: v = '0;
					3: v = -16'sd1;
					default: v = Q_ONE;
				endcase
			end
			default: v = DATA_W'($urandom());
		endcase
		return v;
	endfunction

	function automatic op_item_t rand_op();
		op_item_t it;
		int       pick;
		pick      = $urandom_range(0, 19);
		it.a_real = rand_part();
		it.a_imag = rand_part();
		it.b_real = rand_part();
		it.b_imag = rand_part();
		if (pick < 4)
			it.mode = MODE_ADD;
		else if (pick < 8)
			it.mode = MODE_SUB;
		else if (pick < 12)
			it.mode = MODE_MUL;
		else if (pick < 16)
			it.mode = MODE_EQ;
		else if (pick < 19)
			it.mode = MODE_MAG;
		else
			it.mode = 3'($urandom_range(5, 7));
		// equality is only interesting if the operands often match in one or both parts
		if (it.mode == MODE_EQ) begin
			case ($urandom_range(0, 3))
				0: begin
					it.b_real = it.a_real;
					it.b_imag = it.a_imag;
				end
				1: it.b_real = it.a_real;
				2: it.b_imag = it.a_imag;
				default: begin
				end
			endcase
		end
		return it;
	endfunction

	// one op transfer; entered and left at a falling edge, so valid is raised or held at most
	// once per time step
	task automatic send_op(input op_item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			op_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op       = it;
		op_valid = 1'b1;
		// ready is sampled before the edge takes effect, as the unit sees it
		do
			@(posedge clk);
		while (!op_ready);
		sb.note_op(it);
		@(negedge clk);
	endtask

	// hold the op channel quiet until every outstanding result has come back
	task automatic drain_results();
		op_valid = 1'b0;
		while (sb.pending_count() != 0)
			@(negedge clk);
	endtask

	// result side: random stall before each transfer, then hold ready until one is taken
	initial begin
		int stall;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				res_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready = 1'b1;
			do
				@(posedge clk);
			while (!res_valid);
			sb.check_res(res);
			@(negedge clk);
		end
	end

	initial begin
		arst_n   = 1'b0;
		op_valid = 1'b0;
		op       = '0;
		idle_on  = 1'b1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed opening: saturation at both ends of each arithmetic mode
		send_op(make_op(MODE_ADD, Q_MAX, Q_MAX, Q_MAX, Q_ONE));
		send_op(make_op(MODE_ADD, Q_MIN, Q_MIN, Q_MIN, -16'sd1));
		send_op(make_op(MODE_ADD, '0, '0, '0, '0));
		send_op(make_op(MODE_SUB, Q_MAX, Q_MIN, Q_MIN, Q_MAX));
		send_op(make_op(MODE_SUB, Q_MIN, Q_MAX, Q_ONE, -16'sd1));
		send_op(make_op(MODE_SUB, Q_ONE, -16'sd1, Q_ONE, -16'sd1));
		// multiply: unity, floor of small negative products, cancelling and clamping products
		send_op(make_op(MODE_MUL, Q_ONE, '0, Q_ONE, '0));
		send_op(make_op(MODE_MUL, -16'sd1, '0, 16'sd1, '0));
		send_op(make_op(MODE_MUL, 16'sd3, -16'sd5, -16'sd7, 16'sd11));
		send_op(make_op(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_op(make_op(MODE_MUL, Q_MIN, '0, Q_MAX, '0));
		send_op(make_op(MODE_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MIN));
		send_op(make_op(MODE_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
		// equality: both parts, only one part matching, extremes
		send_op(make_op(MODE_EQ, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
		send_op(make_op(MODE_EQ, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
		send_op(make_op(MODE_EQ, Q_ONE, '0, Q_ONE, -16'sd1));
		send_op(make_op(MODE_EQ, '0, '0, '0, '0));
		// magnitude: largest modulus, one axis, a 3-4-5 triangle, zero
		send_op(make_op(MODE_MAG, Q_MIN, Q_MIN, Q_MAX, Q_MAX));
		send_op(make_op(MODE_MAG, Q_MAX, '0, '0, '0));
		send_op(make_op(MODE_MAG, 16'sd3, -16'sd4, Q_MIN, Q_MIN));
		send_op(make_op(MODE_MAG, '0, '0, Q_ONE, Q_ONE));
		// spare codes return an all-zero result
		send_op(make_op(MODE_SPARE_5, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_op(make_op(MODE_SPARE_6, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
		send_op(make_op(MODE_SPARE_7, -16'sd1, Q_ONE, -16'sd1, Q_ONE));
		drain_results();

		// random run; idling is switched on and off in stretches, and the sender pauses once
		// midway for the pipeline to run empty
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (n == RANDOM_OPS / 2)
				drain_results();
			send_op(rand_op());
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
